>>> hw/rtl/pps_pkg.sv
// shared types and constants of the preemptive priority scheduler
// no dependencies; used by pps_ctrl, pps_datapath and the top level
package pps_pkg;

   localparam int unsigned MAX_TASKS_DEFAULT = 16;
   localparam int unsigned SLOT_W            = 4;
   localparam int unsigned TIME_W            = 16;
   localparam int unsigned PRIO_W            = 8;
   localparam int unsigned BURST_W           = 16;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic scan_step;
      logic update;
      logic publish;
   } pps_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_last;
      logic rsp_busy;
   } pps_status_type;

endpackage

>>> hw/rtl/preemptive_priority_scheduler_unit.sv
// A load request passes through accept, decode, slot write and response; a tick request passes
// through accept, one slot table read per slot, a final compare, the write-back of the chosen
// slot and response; the single read port of the slot table sets the scan length. A new request
// is accepted as soon as the previous one has reached the response register, and a response still
// held by rsp_stall only delays the next response.
// top level of the scheduler; instantiates pps_ctrl and pps_datapath, uses pps_pkg
module preemptive_priority_scheduler_unit #(
   parameter int unsigned MAX_TASKS = pps_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [pps_pkg::SLOT_W-1:0]   req_slot,
   input  logic [pps_pkg::TIME_W-1:0]   req_arrival_time,
   input  logic [pps_pkg::PRIO_W-1:0]   req_priority_level,
   input  logic [pps_pkg::BURST_W-1:0]  req_burst_length,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ran_valid,
   output logic [pps_pkg::SLOT_W-1:0]   rsp_ran_slot,
   output logic                         rsp_finished,
   output logic [pps_pkg::TIME_W-1:0]   rsp_now_time,
   output logic                         rsp_all_done
);

   pps_pkg::pps_cmd_type    cmd;
   pps_pkg::pps_status_type status;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pps_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_slot           (req_slot),
      .req_arrival_time   (req_arrival_time),
      .req_priority_level (req_priority_level),
      .req_burst_length   (req_burst_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ran_valid      (rsp_ran_valid),
      .rsp_ran_slot       (rsp_ran_slot),
      .rsp_finished       (rsp_finished),
      .rsp_now_time       (rsp_now_time),
      .rsp_all_done       (rsp_all_done)
   );

   // one request in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // a held response is never overwritten
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid && rsp_stall))
      else $error("response overwritten while stalled");

   // datapath commands are exclusive
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.load_write, cmd.scan_step, cmd.update, cmd.publish}))
      else $error("overlapping datapath commands");

   // a response follows a publish
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("publish without response");

endmodule

>>> hw/rtl/pps_ctrl.sv
// sequencer of the scheduler: accept, load or scan/update, publish
// depends on pps_pkg for the command and status types
module pps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pps_pkg::pps_status_type status,
   output pps_pkg::pps_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_LOAD    = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_DRAIN   = 6'b001000,
      ST_UPDATE  = 6'b010000,
      ST_PUBLISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.is_tick) begin
               state_in = ST_LOAD;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = ST_PUBLISH;
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!status.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/pps_datapath.sv
// slot table, scan compare, counters, time and response register
// depends on pps_pkg; driven by commands from pps_ctrl
module pps_datapath #(
   parameter int unsigned MAX_TASKS = pps_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pps_pkg::pps_cmd_type              cmd,
   output pps_pkg::pps_status_type           status,
   input  logic                              req_action,
   input  logic [pps_pkg::SLOT_W-1:0]        req_slot,
   input  logic [pps_pkg::TIME_W-1:0]        req_arrival_time,
   input  logic [pps_pkg::PRIO_W-1:0]        req_priority_level,
   input  logic [pps_pkg::BURST_W-1:0]       req_burst_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ran_valid,
   output logic [pps_pkg::SLOT_W-1:0]        rsp_ran_slot,
   output logic                              rsp_finished,
   output logic [pps_pkg::TIME_W-1:0]        rsp_now_time,
   output logic                              rsp_all_done
);

   localparam int unsigned IDX_W = $clog2(MAX_TASKS);
   localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

   // slot table
   logic [pps_pkg::TIME_W-1:0]  arrival_mem   [MAX_TASKS];
   logic [pps_pkg::PRIO_W-1:0]  priority_mem  [MAX_TASKS];
   logic [pps_pkg::BURST_W-1:0] remaining_mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]        loaded_ff;
   logic [MAX_TASKS-1:0]        loaded_in;
   logic [MAX_TASKS-1:0]        done_ff;
   logic [MAX_TASKS-1:0]        done_in;

   // captured request
   logic                        action_ff;
   logic [pps_pkg::SLOT_W-1:0]  slot_ff;
   logic [pps_pkg::TIME_W-1:0]  arrival_ff;
   logic [pps_pkg::PRIO_W-1:0]  prio_ff;
   logic [pps_pkg::BURST_W-1:0] burst_ff;

   // scan pipeline
   logic [IDX_W-1:0]            idx_ff;
   logic [IDX_W-1:0]            idx_in;
   logic                        rd_vld_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic                        rd_loaded_ff;
   logic                        rd_done_ff;
   logic [pps_pkg::TIME_W-1:0]  rd_arrival_ff;
   logic [pps_pkg::PRIO_W-1:0]  rd_prio_ff;
   logic [pps_pkg::BURST_W-1:0] rd_rem_ff;
   logic                        found_ff;
   logic                        found_in;
   logic [IDX_W-1:0]            best_idx_ff;
   logic [IDX_W-1:0]            best_idx_in;
   logic [pps_pkg::PRIO_W-1:0]  best_prio_ff;
   logic [pps_pkg::PRIO_W-1:0]  best_prio_in;
   logic [pps_pkg::BURST_W-1:0] best_rem_ff;
   logic [pps_pkg::BURST_W-1:0] best_rem_in;
   logic                        cand;

   // counters and time
   logic [CNT_W-1:0]            loaded_cnt_ff;
   logic [CNT_W-1:0]            loaded_cnt_in;
   logic [CNT_W-1:0]            done_cnt_ff;
   logic [CNT_W-1:0]            done_cnt_in;
   logic [pps_pkg::TIME_W-1:0]  time_ff;
   logic [pps_pkg::TIME_W-1:0]  time_in;

   // per-item result flags
   logic                        ran_ff;
   logic                        ran_in;
   logic                        fin_ff;
   logic                        fin_in;

   // response register
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_ran_ff;
   logic [pps_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic                        rsp_fin_ff;
   logic [pps_pkg::TIME_W-1:0]  rsp_time_ff;
   logic                        rsp_all_ff;

   logic                        slot_ok;
   logic [IDX_W-1:0]            load_idx;
   logic [pps_pkg::BURST_W-1:0] new_rem;

   assign slot_ok  = (32'(slot_ff) < 32'(MAX_TASKS));
   assign load_idx = IDX_W'(slot_ff);
   assign new_rem  = best_rem_ff - pps_pkg::BURST_W'(1);

   assign status.is_tick   = (action_ff == pps_pkg::ACTION_TICK);
   assign status.scan_last = (idx_ff == LAST_IDX);
   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign cand = rd_vld_ff && rd_loaded_ff && !rd_done_ff && (rd_arrival_ff <= time_ff);

   always_comb begin
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_rem_in  = best_rem_ff;
      if (cmd.capture) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else begin
         if (cmd.scan_step) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (cand && (!found_ff || (rd_prio_ff < best_prio_ff))) begin
            found_in     = 1'b1;
            best_idx_in  = rd_idx_ff;
            best_prio_in = rd_prio_ff;
            best_rem_in  = rd_rem_ff;
         end
      end
   end

   always_comb begin
      loaded_in     = loaded_ff;
      done_in       = done_ff;
      loaded_cnt_in = loaded_cnt_ff;
      done_cnt_in   = done_cnt_ff;
      time_in       = time_ff;
      ran_in        = ran_ff;
      fin_in        = fin_ff;
      if (cmd.load_write) begin
         ran_in = 1'b0;
         fin_in = 1'b0;
         if (slot_ok) begin
            loaded_in[load_idx] = 1'b1;
            done_in[load_idx]   = (burst_ff == '0);
            if (!loaded_ff[load_idx]) begin
               loaded_cnt_in = loaded_cnt_ff + CNT_W'(1);
            end
            if (loaded_ff[load_idx] && done_ff[load_idx] && (burst_ff != '0)) begin
               done_cnt_in = done_cnt_ff - CNT_W'(1);
            end else if (!(loaded_ff[load_idx] && done_ff[load_idx]) && (burst_ff == '0)) begin
               done_cnt_in = done_cnt_ff + CNT_W'(1);
            end
         end
      end else if (cmd.update) begin
         ran_in = found_ff;
         fin_in = found_ff && (new_rem == '0);
         if (found_ff && (new_rem == '0)) begin
            done_in[best_idx_ff] = 1'b1;
            done_cnt_in          = done_cnt_ff + CNT_W'(1);
         end
         if (time_ff != '1) begin
            time_in = time_ff + pps_pkg::TIME_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // slot table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         arrival_mem[load_idx]   <= arrival_ff;
         priority_mem[load_idx]  <= prio_ff;
         remaining_mem[load_idx] <= burst_ff;
      end else if (cmd.update && found_ff) begin
         remaining_mem[best_idx_ff] <= new_rem;
      end
      rd_arrival_ff <= arrival_mem[idx_ff];
      rd_prio_ff    <= priority_mem[idx_ff];
      rd_rem_ff     <= remaining_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= idx_ff;
      rd_loaded_ff <= loaded_ff[idx_ff];
      rd_done_ff   <= done_ff[idx_ff];
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_rem_ff  <= best_rem_in;
      ran_ff       <= ran_in;
      fin_ff       <= fin_in;
      if (cmd.capture) begin
         action_ff  <= req_action;
         slot_ff    <= req_slot;
         arrival_ff <= req_arrival_time;
         prio_ff    <= req_priority_level;
         burst_ff   <= req_burst_length;
      end
      if (cmd.publish) begin
         rsp_ran_ff  <= ran_ff;
         rsp_slot_ff <= ran_ff ? pps_pkg::SLOT_W'(best_idx_ff) : '0;
         rsp_fin_ff  <= fin_ff;
         rsp_time_ff <= time_ff;
         rsp_all_ff  <= (done_cnt_ff == loaded_cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         done_ff       <= '0;
         loaded_cnt_ff <= '0;
         done_cnt_ff   <= '0;
         time_ff       <= '0;
         found_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         loaded_ff     <= loaded_in;
         done_ff       <= done_in;
         loaded_cnt_ff <= loaded_cnt_in;
         done_cnt_ff   <= done_cnt_in;
         time_ff       <= time_in;
         found_ff      <= found_in;
         rd_vld_ff     <= cmd.scan_step;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ran_valid = rsp_ran_ff;
   assign rsp_ran_slot  = rsp_slot_ff;
   assign rsp_finished  = rsp_fin_ff;
   assign rsp_now_time  = rsp_time_ff;
   assign rsp_all_done  = rsp_all_ff;

endmodule
